// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk and held off by arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int CMD_W  = 2;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int X_W    = 7;
	localparam int Y_W    = 5;

	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'd32;
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT   = 2'd0,
		CMD_SET   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [X_W-1:0]    col_now;
		logic [Y_W-1:0]    row_now;
		logic [CHAR_W-1:0] read_char;
		logic [ATTR_W-1:0] read_attr;
		logic              scrolled;
	} result_t;

endpackage

// ----- rtl/core/tcw_req_if.sv -----
// ----------------------------------------------------------------------------
// tcw_req_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tcw_req_if;
	logic                      valid;
	logic                      ready;
	logic [tcw_pkg::CMD_W-1:0]  cmd;
	logic [tcw_pkg::CHAR_W-1:0] char_code;
	logic [tcw_pkg::X_W-1:0]    cursor_x;
	logic [tcw_pkg::Y_W-1:0]    cursor_y;

	modport source (output valid, cmd, char_code, cursor_x, cursor_y, input ready);
	modport sink   (input valid, cmd, char_code, cursor_x, cursor_y, output ready);
endinterface

// ----- rtl/core/tcw_rsp_if.sv -----
// ----------------------------------------------------------------------------
// tcw_rsp_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tcw_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [tcw_pkg::X_W-1:0]    col_now;
	logic [tcw_pkg::Y_W-1:0]    row_now;
	logic [tcw_pkg::CHAR_W-1:0] read_char;
	logic [tcw_pkg::ATTR_W-1:0] read_attr;
	logic                      scrolled;

	modport source (output valid, col_now, row_now, read_char, read_attr, scrolled,
		input ready);
	modport sink   (input valid, col_now, row_now, read_char, read_attr, scrolled,
		output ready);
endinterface

// ----- rtl/core/tcw_engine.sv -----
// ----------------------------------------------------------------------------
// tcw_engine
// Screen memory with its command sequencer: cell writes, reads, scroll copy
// and blanking sweeps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_engine #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic [tcw_pkg::CMD_W-1:0]  cmd,
	input  logic [tcw_pkg::CHAR_W-1:0] char_code,
	input  logic [tcw_pkg::X_W-1:0]    cursor_x,
	input  logic [tcw_pkg::Y_W-1:0]    cursor_y,
	input  logic [tcw_pkg::ATTR_W-1:0] text_color,
	output logic                       res_valid,
	input  logic                       res_ready,
	output tcw_pkg::result_t           res
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(CELLS + 1);
	localparam int XW    = $clog2(COLUMNS + 1);
	localparam int YW    = $clog2(ROWS);
	localparam int DW    = tcw_pkg::ATTR_W + tcw_pkg::CHAR_W;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PUTW,
		ST_COPY,
		ST_SWEEP,
		ST_RESP
	} state_t;

	state_t                     state_q;
	logic [XW-1:0]              col_q;
	logic [YW-1:0]              row_q;
	logic [CW-1:0]              cnt_q;
	logic [tcw_pkg::CHAR_W-1:0] char_q;
	logic                       nl_q;
	logic                       scr_q;
	logic                       rd_q;
	logic                       copy_s1;
	logic [AW-1:0]              dst_s1;

	logic [DW-1:0] mem [CELLS];
	logic [DW-1:0] rdata_q;

	logic          accept;
	logic          wrap;
	logic          last_row;
	logic [XW-1:0] x_sat;
	logic [YW-1:0] y_sat;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] rd_addr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [DW-1:0] wdata;
	logic          re;
	logic [AW-1:0] raddr;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign wrap      = (char_code == tcw_pkg::NEWLINE_CHAR) || (col_q == XW'(COLUMNS));
	assign last_row  = (row_q == YW'(ROWS - 1));
	assign x_sat     = (int'(cursor_x) >= COLUMNS) ? XW'(COLUMNS - 1) : XW'(cursor_x);
	assign y_sat     = (int'(cursor_y) >= ROWS) ? YW'(ROWS - 1) : YW'(cursor_y);
	assign cur_addr  = AW'(int'(row_q) * COLUMNS + int'(col_q));
	assign rd_addr   = AW'(int'(y_sat) * COLUMNS + int'(x_sat));

	always_comb begin
		we    = 1'b0;
		waddr = cur_addr;
		wdata = {text_color, char_q};
		re    = 1'b0;
		raddr = rd_addr;
		case (state_q)
			ST_INIT: begin
				we    = 1'b1;
				waddr = cnt_q[AW-1:0];
				wdata = {{tcw_pkg::ATTR_W{1'b0}}, tcw_pkg::BLANK_CHAR};
			end
			ST_IDLE: begin
				if (accept && (cmd == tcw_pkg::CMD_PUT) && !wrap) begin
					we    = 1'b1;
					wdata = {text_color, char_code};
				end
				if (accept && (cmd == tcw_pkg::CMD_READ)) begin
					re = 1'b1;
				end
			end
			ST_PUTW: begin
				we = 1'b1;
			end
			ST_COPY: begin
				we    = copy_s1;
				waddr = dst_s1;
				wdata = rdata_q;
				re    = (cnt_q != CW'(CELLS));
				raddr = cnt_q[AW-1:0];
			end
			ST_SWEEP: begin
				we    = 1'b1;
				waddr = cnt_q[AW-1:0];
				wdata = {text_color, tcw_pkg::BLANK_CHAR};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			col_q   <= '0;
			row_q   <= '0;
			cnt_q   <= '0;
			char_q  <= '0;
			nl_q    <= 1'b0;
			scr_q   <= 1'b0;
			rd_q    <= 1'b0;
			copy_s1 <= 1'b0;
			dst_s1  <= '0;
		end else begin
			case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						char_q <= char_code;
						nl_q   <= (char_code == tcw_pkg::NEWLINE_CHAR);
						scr_q  <= 1'b0;
						rd_q   <= (cmd == tcw_pkg::CMD_READ);
						case (cmd)
							tcw_pkg::CMD_PUT: begin
								if (!wrap) begin
									col_q   <= col_q + 1'b1;
									state_q <= ST_RESP;
								end else begin
									col_q <= '0;
									if (!last_row) begin
										row_q   <= row_q + 1'b1;
										state_q <= (char_code == tcw_pkg::NEWLINE_CHAR) ?
											ST_RESP : ST_PUTW;
									end else begin
										scr_q   <= 1'b1;
										cnt_q   <= CW'(COLUMNS);
										copy_s1 <= 1'b0;
										state_q <= ST_COPY;
									end
								end
							end
							tcw_pkg::CMD_SET: begin
								col_q   <= x_sat;
								row_q   <= y_sat;
								state_q <= ST_RESP;
							end
							tcw_pkg::CMD_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_SWEEP;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_PUTW: begin
					col_q   <= col_q + 1'b1;
					state_q <= ST_RESP;
				end
				ST_COPY: begin
					if (cnt_q != CW'(CELLS)) begin
						cnt_q   <= cnt_q + 1'b1;
						copy_s1 <= 1'b1;
						dst_s1  <= AW'(cnt_q - CW'(COLUMNS));
					end else begin
						copy_s1 <= 1'b0;
						cnt_q   <= CW'((ROWS - 1) * COLUMNS);
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(CELLS - 1)) begin
						if (scr_q && !nl_q) begin
							state_q <= ST_PUTW;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid     = (state_q == ST_RESP);
	assign res.col_now   = tcw_pkg::X_W'(col_q);
	assign res.row_now   = tcw_pkg::Y_W'(row_q);
	assign res.read_char = rd_q ? rdata_q[tcw_pkg::CHAR_W-1:0] : '0;
	assign res.read_attr = rd_q ? rdata_q[DW-1:tcw_pkg::CHAR_W] : '0;
	assign res.scrolled  = scr_q;

endmodule

// ----- rtl/core/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console with cursor, line wrap, scroll and cell read.
//
// Channel   Dir  Payload                                     Transfer when
// req       in   cmd, char_code, cursor_x, cursor_y          valid && ready
// rsp       out  col_now, row_now, read_char, read_attr,     valid && ready
//                scrolled
// cfg       in   cfg_wdata (text color)                      cfg_we
//
// A put at a full row wraps to the next row before its character is written. A scroll
// copies every row up through the single memory port pair, blanks the last row and then
// writes a following character; clear blanks every cell. After reset the memory is blanked
// with req.ready low. One command is in work at a time; the next transfer is taken once
// its result has moved to the output register, which may still be waiting on rsp.ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata,
	tcw_req_if.sink                    req,
	tcw_rsp_if.source                  rsp
);

`include "assert_macros.svh"

	localparam logic [tcw_pkg::Y_W-1:0] SCROLL_ROW = tcw_pkg::Y_W'(ROWS - 1);

	logic [tcw_pkg::ATTR_W-1:0] text_color_q;
	logic                       res_valid;
	logic                       res_ready;
	tcw_pkg::result_t           res;
	logic                       rsp_valid_q;
	tcw_pkg::result_t           rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= '0;
		end else if (cfg_we) begin
			text_color_q <= cfg_wdata;
		end
	end

	tcw_engine #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.cmd        (req.cmd),
		.char_code  (req.char_code),
		.cursor_x   (req.cursor_x),
		.cursor_y   (req.cursor_y),
		.text_color (text_color_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.col_now   = rsp_q.col_now;
	assign rsp.row_now   = rsp_q.row_now;
	assign rsp.read_char = rsp_q.read_char;
	assign rsp.read_attr = rsp_q.read_attr;
	assign rsp.scrolled  = rsp_q.scrolled;

	`TCW_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready,
		"A second command was offered ready right after a transfer.")
	`TCW_ASSERT_SAME(a_ready_no_result, req.ready, !res_valid,
		"The engine took commands while a result was pending.")
	`TCW_ASSERT_NEXT(a_result_lands, res_valid && res_ready, rsp.valid,
		"A finished result did not reach the output register.")
	`TCW_ASSERT_SAME(a_scroll_row, rsp.valid && rsp.scrolled, rsp.row_now == SCROLL_ROW,
		"A scrolled result does not report the last row.")

endmodule
